// ===== sv/wsdf_pkg.sv =====
package wsdf_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_REJECT  = 2'd2;

  // Frame header constants.
  localparam logic [7:0] FRAME_TYPE_TEXT = 8'h81;
  localparam logic [6:0] LEN_MEDIUM      = 7'h7e;
  localparam logic [6:0] LEN_LONG        = 7'h7f;

  // Number of extension bytes for the two extended length forms.
  localparam logic [3:0] EXT_MEDIUM_BYTES = 4'd2;
  localparam logic [3:0] EXT_LONG_BYTES   = 4'd8;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       last_of_frame;
  } result_t;

endpackage

// ===== sv/wsdf_parse.sv =====
module wsdf_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output wsdf_pkg::result_t   res
);

  localparam logic [2:0] PH_TYPE    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [3:0]  ext_bytes_left, ext_bytes_left_next;
  logic [31:0] payload_length, payload_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [2:0]  mask_bytes_seen, mask_bytes_seen_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [1:0]  key_index, key_index_next;
  logic        has_result;
  logic [6:0]  len_code;
  logic [7:0]  key_byte;

  assign len_code = rx_byte[6:0];
  assign key_byte = mask_key[{key_index, 3'b000} +: 8];

  always_comb begin
    phase_next             = phase;
    ext_bytes_left_next    = ext_bytes_left;
    payload_length_next    = payload_length;
    mask_key_next          = mask_key;
    mask_bytes_seen_next   = mask_bytes_seen;
    payload_remaining_next = payload_remaining;
    key_index_next         = key_index;
    has_result             = 1'b0;
    res                    = '0;

    unique case (phase)
      PH_LEN: begin
        mask_key_next        = '0;
        mask_bytes_seen_next = '0;
        if (len_code < wsdf_pkg::LEN_MEDIUM) begin
          payload_length_next = {25'd0, len_code};
          phase_next          = PH_MASK;
        end else begin
          payload_length_next = '0;
          ext_bytes_left_next = (len_code == wsdf_pkg::LEN_MEDIUM) ?
                                wsdf_pkg::EXT_MEDIUM_BYTES : wsdf_pkg::EXT_LONG_BYTES;
          phase_next          = PH_EXT;
        end
      end
      PH_EXT: begin
        // Shifting into 32 bits drops the upper half of the long form.
        payload_length_next = {payload_length[23:0], rx_byte};
        ext_bytes_left_next = ext_bytes_left - 4'd1;
        if (ext_bytes_left_next == 4'd0) begin
          phase_next = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_key_next[{mask_bytes_seen[1:0], 3'b000} +: 8] = rx_byte;
        mask_bytes_seen_next = mask_bytes_seen + 3'd1;
        if (mask_bytes_seen[1:0] == 2'd3) begin
          if (payload_length == 32'd0) begin
            phase_next        = PH_TYPE;
            has_result        = 1'b1;
            res.status        = wsdf_pkg::STATUS_EMPTY;
            res.last_of_frame = 1'b1;
          end else begin
            payload_remaining_next = payload_length;
            key_index_next         = '0;
            phase_next             = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        key_index_next         = key_index + 2'd1;
        payload_remaining_next = payload_remaining - 32'd1;
        has_result             = 1'b1;
        res.status             = wsdf_pkg::STATUS_PAYLOAD;
        res.data               = rx_byte ^ key_byte;
        res.last_of_frame      = (payload_remaining == 32'd1);
        if (payload_remaining == 32'd1) begin
          phase_next = PH_TYPE;
        end
      end
      default: begin
        // Type phase, and any code that means nothing, waits for a text frame.
        if (rx_byte == wsdf_pkg::FRAME_TYPE_TEXT) begin
          phase_next = PH_LEN;
        end else begin
          phase_next = PH_TYPE;
          has_result = 1'b1;
          res.status = wsdf_pkg::STATUS_REJECT;
          res.data   = rx_byte;
        end
      end
    endcase
  end

  assign res_valid = accept & has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TYPE;
      ext_bytes_left    <= '0;
      payload_length    <= '0;
      mask_key          <= '0;
      mask_bytes_seen   <= '0;
      payload_remaining <= '0;
      key_index         <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      ext_bytes_left    <= ext_bytes_left_next;
      payload_length    <= payload_length_next;
      mask_key          <= mask_key_next;
      mask_bytes_seen   <= mask_bytes_seen_next;
      payload_remaining <= payload_remaining_next;
      key_index         <= key_index_next;
    end
  end

  // A frame in its payload always has at least one byte to come.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_remaining != 32'd0))
    else $error("payload phase with nothing remaining");

  // The key count never passes four while the key is being collected.
  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MASK) |-> (mask_bytes_seen < 3'd4))
    else $error("mask byte count overran");

  // Only a payload byte can close a non-empty frame.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && has_result && res.status == wsdf_pkg::STATUS_PAYLOAD && res.last_of_frame)
      |=> (phase == PH_TYPE))
    else $error("last payload byte did not return to the type phase");

endmodule

// ===== sv/websocket_frame_deframer_unmask.sv =====
// Receive-side WebSocket deframer for client text frames. Each request on the
// item channel carries one byte of the client stream in rx_byte. A frame must
// open with the type byte 0x81; any other byte in that position is passed out
// with status 2 and dropped, and the block keeps looking for a frame start.
// The length byte's mask bit is ignored; lengths 126 and 127 take 2 and 8
// big-endian extension bytes, and of the 8-byte form only the low 32 bits are
// kept. Four mask-key bytes always follow, then each payload byte leaves as a
// status-0 request carrying the unmasked byte, with last_of_frame set on the
// final one. A zero-length frame gives a single status-1 request with
// last_of_frame set once its key has arrived. Header and key bytes give no
// result. The block takes one byte per clock: the parser state is updated in
// the same cycle as the byte is accepted, and the result sits in an output
// register backed by a one-entry skid buffer, so item_stall rises only when
// that buffer is occupied because the result side is stalling.
module websocket_frame_deframer_unmask (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] rx_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] status,
  output logic [7:0] data,
  output logic       last_of_frame
);

  logic              accept;
  logic              par_valid;
  wsdf_pkg::result_t par_res;
  wsdf_pkg::result_t out_reg;
  wsdf_pkg::result_t skid_reg;
  logic              skid_valid;
  logic              take;

  // The skid buffer being full is the only reason to hold off the sender.
  assign item_stall = skid_valid;
  assign accept     = item_valid & ~item_stall;
  assign take       = result_valid & ~result_stall;

  wsdf_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (par_valid),
    .res       (par_res)
  );

  // When the output register is free, it is refilled from the skid buffer
  // first, otherwise from the parser. A fresh result that meets a stalled
  // output register goes into the skid buffer instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        out_reg      <= skid_reg;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= par_valid;
        out_reg      <= par_res;
      end
    end else if (par_valid) begin
      skid_valid <= 1'b1;
      skid_reg   <= par_res;
    end
  end

  assign status        = out_reg.status;
  assign data          = out_reg.data;
  assign last_of_frame = out_reg.last_of_frame;

  // The skid buffer is only ever occupied behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid buffer full while output register empty");

  // A result produced while the output is stalled must be caught by the skid.
  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && par_valid) |=> skid_valid)
    else $error("result lost behind a stalled output");

  // Only the three defined status codes reach the port.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == wsdf_pkg::STATUS_PAYLOAD ||
                      status == wsdf_pkg::STATUS_EMPTY ||
                      status == wsdf_pkg::STATUS_REJECT))
    else $error("undefined status code on the result port");

  // An empty-frame result always closes its frame.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == wsdf_pkg::STATUS_EMPTY) |-> last_of_frame)
    else $error("empty-frame result without last_of_frame");

endmodule
